// File: design/ray_sphere_intersect_defines.svh
// Assertion macros shared by the checker of the ray-sphere block.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define RSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: design/rsi_pkg.sv
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int IN_W           = 16;
  localparam int DIST_FRAC_BITS = 16;
  localparam int T_W            = 32;

  // Exact integer widths of the quadratic terms.
  localparam int A_W = 32;                  // d.d
  localparam int H_W = 33;                  // d.o, signed
  localparam int C_W = 34;                  // o.o - r*r, signed
  localparam int P_W = 64;                  // h*h and a*|c|
  localparam int D_W = 66;                  // discriminant, signed

  // Square root of D scaled by 2^(2*DIST_FRAC_BITS), two radicand bits per cell.
  localparam int NW     = D_W + 2 * DIST_FRAC_BITS;
  localparam int ROOT_W = NW / 2;
  localparam int REM_W  = ROOT_W + 3;

  // Root numerators and the unsigned dividend, one quotient bit per cell.
  localparam int NUM_W = H_W + DIST_FRAC_BITS + 2;
  localparam int U_W   = NUM_W - 1;

  typedef struct packed {
    logic                  vld;
    logic                  deg;
    logic                  miss;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
    logic [NW-1:0]         n;
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
  } sq_bus_t;

  typedef struct packed {
    logic           neg;
    logic [U_W-1:0] u;
    logic [A_W-1:0] rem;
    logic [U_W-1:0] q;
  } dv_lane_t;

  typedef struct packed {
    logic              vld;
    logic              deg;
    logic              miss;
    logic [A_W-1:0]    a;
    dv_lane_t [1:0]    lane;
  } dv_bus_t;

endpackage

// File: design/rsi_if.sv
`timescale 1ns / 1ps
interface rsi_in_if;
  import rsi_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] origin_x;
  logic signed [IN_W-1:0] origin_y;
  logic signed [IN_W-1:0] origin_z;
  logic signed [IN_W-1:0] dir_x;
  logic signed [IN_W-1:0] dir_y;
  logic signed [IN_W-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsi_out_if;
  import rsi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic signed [T_W-1:0] t_near;
  logic signed [T_W-1:0] t_far;
  logic                  degenerate;
  logic                  saturated;

  modport source (output valid, hit, t_near, t_far, degenerate, saturated, input ready);
  modport sink   (input valid, hit, t_near, t_far, degenerate, saturated, output ready);
endinterface

// File: design/rsi_sqrt_cell.sv
`timescale 1ns / 1ps
module rsi_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  rsi_pkg::sq_bus_t d_i,
  output rsi_pkg::sq_bus_t d_o
);
  import rsi_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;
  sq_bus_t          bus_nxt;
  sq_bus_t          bus_r;

  // One restoring square-root step: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem_sh  = {d_i.rem[REM_W-3:0], d_i.n[NW-1 -: 2]};
    trial   = {{(REM_W-ROOT_W-2){1'b0}}, d_i.root, 2'b01};
    take    = (rem_sh >= trial);
    bus_nxt = d_i;
    bus_nxt.n    = {d_i.n[NW-3:0], 2'b00};
    bus_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    bus_nxt.root = {d_i.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= '0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign d_o = bus_r;

endmodule

// File: design/rsi_div_cell.sv
`timescale 1ns / 1ps
module rsi_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  rsi_pkg::dv_bus_t d_i,
  output rsi_pkg::dv_bus_t d_o
);
  import rsi_pkg::*;

  logic [A_W:0] rem_sh [2];
  logic [A_W:0] diff   [2];
  logic         take   [2];
  dv_bus_t      bus_nxt;
  dv_bus_t      bus_r;

  // One restoring division step per lane; both lanes share the divisor.
  always_comb begin
    bus_nxt = d_i;
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {d_i.lane[l].rem, d_i.lane[l].u[U_W-1]};
      diff[l]   = rem_sh[l] - {1'b0, d_i.a};
      take[l]   = (rem_sh[l] >= {1'b0, d_i.a});
      bus_nxt.lane[l].u   = {d_i.lane[l].u[U_W-2:0], 1'b0};
      bus_nxt.lane[l].rem = take[l] ? diff[l][A_W-1:0] : rem_sh[l][A_W-1:0];
      bus_nxt.lane[l].q   = {d_i.lane[l].q[U_W-2:0], take[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= '0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign d_o = bus_r;

endmodule

// File: design/ray_sphere_intersect.sv
`timescale 1ns / 1ps
// Ray against a sphere centered at the origin of the ray's frame.
// in_ch carries one ray per beat: origin and direction, signed Q8.8. out_ch
// carries one result beat per ray, in order: hit, t_near and t_far as signed
// Q16.16 distances, degenerate for a zero direction and saturated when a
// root was clamped to the 32-bit range. cfg_we with cfg_wdata writes the
// unsigned Q8.8 radius; write it only while no ray is in flight.
// Throughput is one ray per clock while the output is not stalled. From the
// input beat to the result beat a ray passes five multiply and add
// stages, a row of ROOT_W square-root cells (one root bit each), one stage
// that forms the two numerators, a row of U_W divider cells (one quotient
// bit of each root per cell) and the output register.
// The whole row advances together: when the output register holds a beat
// that the receiver does not take, every stage holds and in_ch.ready drops
// in the same cycle, so nothing is lost and nothing is repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and sets the
// radius to 1.0. No state is kept from one ray to the next.
module ray_sphere_intersect (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [rsi_pkg::IN_W-1:0] cfg_wdata,
  rsi_in_if.sink                  in_ch,
  rsi_out_if.source               out_ch
);
  import rsi_pkg::*;

  localparam logic [IN_W-1:0] RADIUS_RESET = IN_W'(256);

  logic adv;

  // Radius register.
  logic [IN_W-1:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // The pipeline moves whenever the output register is empty or being read.
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: all sixteen-bit products.
  logic                   s1_vld_r;
  logic signed [2*IN_W-1:0] dxdx_r, dydy_r, dzdz_r, dxox_r, dyoy_r, dzoz_r;
  logic signed [2*IN_W-1:0] oxox_r, oyoy_r, ozoz_r;
  logic [2*IN_W-1:0]        rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dxdx_r <= in_ch.dir_x * in_ch.dir_x;
      dydy_r <= in_ch.dir_y * in_ch.dir_y;
      dzdz_r <= in_ch.dir_z * in_ch.dir_z;
      dxox_r <= in_ch.dir_x * in_ch.origin_x;
      dyoy_r <= in_ch.dir_y * in_ch.origin_y;
      dzoz_r <= in_ch.dir_z * in_ch.origin_z;
      oxox_r <= in_ch.origin_x * in_ch.origin_x;
      oyoy_r <= in_ch.origin_y * in_ch.origin_y;
      ozoz_r <= in_ch.origin_z * in_ch.origin_z;
      rr_r   <= radius_r * radius_r;
    end
  end

  // Stage 2: the three dot products give a, h (half of b) and c.
  logic                  s2_vld_r;
  logic [A_W-1:0]        s2_a_r;
  logic signed [H_W-1:0] s2_h_r;
  logic signed [C_W-1:0] s2_c_r;
  logic [2*IN_W-1:0]     oo;

  assign oo = oxox_r[2*IN_W-1:0] + oyoy_r[2*IN_W-1:0] + ozoz_r[2*IN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a_r <= dxdx_r[A_W-1:0] + dydy_r[A_W-1:0] + dzdz_r[A_W-1:0];
      s2_h_r <= H_W'(dxox_r) + H_W'(dyoy_r) + H_W'(dzoz_r);
      s2_c_r <= $signed({2'b00, oo}) - $signed({2'b00, rr_r});
    end
  end

  // Stage 3: magnitudes and the sign of c, zero-direction flag.
  logic                  s3_vld_r;
  logic                  s3_deg_r;
  logic                  s3_cpos_r;
  logic [A_W-1:0]        s3_a_r;
  logic signed [H_W-1:0] s3_h_r;
  logic [A_W-1:0]        s3_habs_r;
  logic [A_W-1:0]        s3_cabs_r;
  logic signed [H_W-1:0] h_neg;
  logic signed [C_W-1:0] c_neg;

  assign h_neg = -s2_h_r;
  assign c_neg = -s2_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_deg_r  <= (s2_a_r == '0);
      s3_cpos_r <= !s2_c_r[C_W-1] && (s2_c_r != '0);
      s3_a_r    <= s2_a_r;
      s3_h_r    <= s2_h_r;
      s3_habs_r <= s2_h_r[H_W-1] ? h_neg[A_W-1:0] : s2_h_r[A_W-1:0];
      s3_cabs_r <= s2_c_r[C_W-1] ? c_neg[A_W-1:0] : s2_c_r[A_W-1:0];
    end
  end

  // Stage 4: h*h and a*|c|.
  logic                  s4_vld_r;
  logic                  s4_deg_r;
  logic                  s4_cpos_r;
  logic [A_W-1:0]        s4_a_r;
  logic signed [H_W-1:0] s4_h_r;
  logic [P_W-1:0]        s4_hh_r;
  logic [P_W-1:0]        s4_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_deg_r  <= s3_deg_r;
      s4_cpos_r <= s3_cpos_r;
      s4_a_r    <= s3_a_r;
      s4_h_r    <= s3_h_r;
      s4_hh_r   <= s3_habs_r * s3_habs_r;
      s4_ac_r   <= s3_a_r * s3_cabs_r;
    end
  end

  // Stage 5: reduced discriminant h*h - a*c; a negative value is a miss.
  logic [D_W-1:0] disc;
  assign disc = s4_cpos_r ? ({2'b00, s4_hh_r} - {2'b00, s4_ac_r})
                          : ({2'b00, s4_hh_r} + {2'b00, s4_ac_r});

  sq_bus_t sq_bus [ROOT_W+1];
  sq_bus_t sq_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_head_r <= '0;
    end else if (adv) begin
      sq_head_r.vld  <= s4_vld_r;
      sq_head_r.deg  <= s4_deg_r;
      sq_head_r.miss <= disc[D_W-1];
      sq_head_r.h    <= s4_h_r;
      sq_head_r.a    <= s4_a_r;
      sq_head_r.n    <= {disc, {(2*DIST_FRAC_BITS){1'b0}}};
      sq_head_r.rem  <= '0;
      sq_head_r.root <= '0;
    end
  end

  assign sq_bus[0] = sq_head_r;

  // Row of square-root cells; the last one holds floor(sqrt(D * 2^(2F))).
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .d_i  (sq_bus[i]),
      .d_o  (sq_bus[i+1])
    );
  end

  // Numerators -h*2^F -/+ S. A negative numerator n is divided as ~n, and
  // the quotient inverted again, which rounds toward minus infinity.
  sq_bus_t                 sq_tail;
  logic signed [NUM_W-1:0] h_sc;
  logic signed [NUM_W-1:0] s_ext;
  logic signed [NUM_W-1:0] num [2];
  dv_bus_t                 dv_bus [U_W+1];
  dv_bus_t                 dv_head_r;

  assign sq_tail = sq_bus[ROOT_W];
  assign h_sc    = {{(NUM_W-H_W-DIST_FRAC_BITS){sq_tail.h[H_W-1]}}, sq_tail.h,
                    {DIST_FRAC_BITS{1'b0}}};
  assign s_ext   = $signed({{(NUM_W-ROOT_W){1'b0}}, sq_tail.root});
  assign num[0]  = -h_sc - s_ext;
  assign num[1]  = -h_sc + s_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_head_r <= '0;
    end else if (adv) begin
      dv_head_r.vld  <= sq_tail.vld;
      dv_head_r.deg  <= sq_tail.deg;
      dv_head_r.miss <= sq_tail.miss;
      dv_head_r.a    <= sq_tail.a;
      for (int l = 0; l < 2; l++) begin
        dv_head_r.lane[l].neg <= num[l][NUM_W-1];
        dv_head_r.lane[l].u   <= num[l][NUM_W-1] ? ~num[l][U_W-1:0] : num[l][U_W-1:0];
        dv_head_r.lane[l].rem <= '0;
        dv_head_r.lane[l].q   <= '0;
      end
    end
  end

  assign dv_bus[0] = dv_head_r;

  // Row of divider cells, both roots side by side.
  for (genvar i = 0; i < U_W; i++) begin : g_div
    rsi_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .d_i  (dv_bus[i]),
      .d_o  (dv_bus[i+1])
    );
  end

  // Clamp to the 32-bit range and register the result beat.
  dv_bus_t        dv_tail;
  logic           over [2];
  logic [T_W-1:0] tval [2];
  logic           hit_nxt;

  assign dv_tail = dv_bus[U_W];
  assign hit_nxt = !dv_tail.deg && !dv_tail.miss;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      over[l] = |dv_tail.lane[l].q[U_W-1:T_W-1];
      if (dv_tail.lane[l].neg) begin
        tval[l] = over[l] ? {1'b1, {(T_W-1){1'b0}}} : ~dv_tail.lane[l].q[T_W-1:0];
      end else begin
        tval[l] = over[l] ? {1'b0, {(T_W-1){1'b1}}} : dv_tail.lane[l].q[T_W-1:0];
      end
    end
  end

  logic           out_valid_r;
  logic           hit_r;
  logic           deg_r;
  logic           sat_r;
  logic [T_W-1:0] t_near_r;
  logic [T_W-1:0] t_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r    <= hit_nxt;
      deg_r    <= dv_tail.deg;
      sat_r    <= hit_nxt && (over[0] || over[1]);
      t_near_r <= hit_nxt ? tval[0] : '0;
      t_far_r  <= hit_nxt ? tval[1] : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.degenerate = deg_r;
  assign out_ch.saturated  = sat_r;
  assign out_ch.t_near     = t_near_r;
  assign out_ch.t_far      = t_far_r;

endmodule

// File: design/rsi_checker.sv
`timescale 1ns / 1ps
`include "ray_sphere_intersect_defines.svh"
module rsi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic signed [rsi_pkg::T_W-1:0] t_near,
  input logic signed [rsi_pkg::T_W-1:0] t_far,
  input logic                          degenerate,
  input logic                          saturated
);
  import rsi_pkg::*;

  // A stalled result beat stays valid and keeps its hit flag and distances.
  `RSI_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(t_near) && $stable(t_far) && $stable(hit))

  // A zero direction never reports a hit.
  `RSI_ASSERT_SAME(a_deg_no_hit, out_valid && degenerate, !hit)

  // A miss carries zero distances and no clamp flag.
  `RSI_ASSERT_SAME(a_miss_zero, out_valid && !hit, t_near == '0 && t_far == '0 && !saturated)

  // The near root never lies beyond the far root.
  `RSI_ASSERT_SAME(a_order, out_valid && hit, t_near <= t_far)

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit       (out_ch.hit),
  .t_near    (out_ch.t_near),
  .t_far     (out_ch.t_far),
  .degenerate(out_ch.degenerate),
  .saturated (out_ch.saturated)
);

// File: tb/ray_sphere_intersect_test.sv
`timescale 1ns / 1ps
module ray_sphere_intersect_test;
  import rsi_pkg::*;

  // One expected result beat of the block.
  typedef struct {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
    logic               degenerate;
    logic               saturated;
  } hit_rec_t;

  // Keeps the radius and the queue of distances still owed by the block.
  class hit_board;
    logic [15:0] radius;
    hit_rec_t    owed[$];
    int          errors;

    function new();
      radius = 16'd256;
      errors = 0;
    endfunction

    // floor(sqrt(n)) by bit-serial search over a 64-bit root.
    function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  cand;
      logic [127:0] sq;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        sq = {64'd0, cand} * {64'd0, cand};
        if (sq <= n) r = cand;
      end
      return r;
    endfunction

    // Division that rounds toward minus infinity.
    function automatic logic signed [127:0] fdiv(logic signed [127:0] n,
                                                  logic signed [127:0] d);
      logic signed [127:0] q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [127:0] v,
                                                  inout logic sat);
      if (v > 128'sd2147483647) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // Notes an accepted ray and works out its result beat.
    function void note_ray(logic signed [15:0] ox, oy, oz, dx, dy, dz);
      logic signed [127:0] a, h, c, disc, s, scaled;
      hit_rec_t            e;
      logic                sat;
      e = '{default: 0};
      sat = 1'b0;
      a = 128'(dx) * dx + 128'(dy) * dy + 128'(dz) * dz;
      h = 128'(dx) * ox + 128'(dy) * oy + 128'(dz) * oz;
      c = 128'(ox) * ox + 128'(oy) * oy + 128'(oz) * oz
          - 128'($signed({1'b0, radius})) * $signed({1'b0, radius});
      if (a == 0) begin
        e.degenerate = 1'b1;
      end else begin
        disc = h * h - a * c;
        if (disc >= 0) begin
          s = $signed({64'd0, isqrt(disc << (2 * DIST_FRAC_BITS))});
          scaled = -h * (128'sd1 <<< DIST_FRAC_BITS);
          e.hit = 1'b1;
          e.t_near = clamp(fdiv(scaled - s, a), sat);
          e.t_far = clamp(fdiv(scaled + s, a), sat);
          e.saturated = sat;
        end
      end
      owed.push_back(e);
    endfunction

    // Checks one accepted result beat against the oldest expectation.
    function void check_beat(hit_rec_t got);
      hit_rec_t e;
      if (owed.size() == 0) begin
        $error("result beat with no ray outstanding");
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, got.hit);
        errors++;
      end
      if (got.t_near !== e.t_near) begin
        $error("t_near: expected %0d, got %0d", e.t_near, got.t_near);
        errors++;
      end
      if (got.t_far !== e.t_far) begin
        $error("t_far: expected %0d, got %0d", e.t_far, got.t_far);
        errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $error("degenerate: expected %0d, got %0d", e.degenerate, got.degenerate);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated: expected %0d, got %0d", e.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  // LATENCY is the depth of the pipeline and sets the drain allowance.
  localparam int LATENCY   = 106;
  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          idle_cycles;

  rsi_in_if  in_ch ();
  rsi_out_if out_ch ();

  hit_board board;

  ray_sphere_intersect dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one ray beat after a random gap and holds it until it is taken.
  task automatic send_ray(logic signed [15:0] ox, oy, oz, dx, dy, dz);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.origin_x <= ox;
    in_ch.origin_y <= oy;
    in_ch.origin_z <= oz;
    in_ch.dir_x    <= dx;
    in_ch.dir_y    <= dy;
    in_ch.dir_z    <= dz;
    do @(posedge clk); while (!in_ch.ready);
    board.note_ray(ox, oy, oz, dx, dy, dz);
  endtask

  // Waits for every owed result, then lets the pipeline go quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // The radius is only written with the pipeline empty.
  task automatic set_radius(logic [15:0] r);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.radius = r;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 1023)) - 512);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Random rays; many aim near the origin so hits and tangencies are common.
  task automatic random_rays(int count);
    logic signed [15:0] ox, oy, oz, dx, dy, dz;
    for (int i = 0; i < count; i++) begin
      ox = rand_coord();
      oy = rand_coord();
      oz = rand_coord();
      if ($urandom_range(0, 2) == 0) begin
        dx = -ox;
        dy = 16'(-oy + $signed(16'($urandom_range(0, 63))) - 16'sd32);
        dz = -oz;
      end else begin
        dx = rand_coord();
        dy = rand_coord();
        dz = rand_coord();
      end
      if ($urandom_range(0, 40) == 0) {dx, dy, dz} = '0;
      send_ray(ox, oy, oz, dx, dy, dz);
    end
  endtask

  // Receiver: random stalls per beat, with occasional stretches of none.
  initial begin : receiver
    int       stall;
    hit_rec_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.hit        = out_ch.hit;
      got.t_near     = out_ch.t_near;
      got.t_far      = out_ch.t_far;
      got.degenerate = out_ch.degenerate;
      got.saturated  = out_ch.saturated;
      board.check_beat(got);
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_cycles = 0;
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays at the reset radius of 1.0.
    send_ray(16'sh0000, 0, 0, 16'sh0100, 0, 0);          // from the center
    send_ray(-16'sh0200, 0, 0, 16'sh0100, 0, 0);         // straight through
    send_ray(-16'sh0200, 16'sh0100, 0, 16'sh0100, 0, 0); // tangent
    send_ray(-16'sh0200, 16'sh0200, 0, 16'sh0100, 0, 0); // clear miss
    send_ray(16'sh0500, 0, 0, 0, 0, 0);                  // zero direction
    send_ray(-16'sh0200, 0, 0, 16'sh0001, 0, 0);         // tiny direction
    send_ray(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_ray(16'sh8000, 0, 0, 16'sh0001, 0, 0);
    send_ray(0, 16'sh7fff, 0, 0, 16'sh8000, 0);
    send_ray(0, 0, 16'sh0300, 0, 0, -16'sh0100);         // hit from behind a wall
    send_ray(0, 0, 16'sh0300, 0, 0, 16'sh0100);          // pointing away
    send_ray(16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff);

    // The sender holds off until the pipeline is empty.
    set_radius(16'd0);
    send_ray(0, 0, 0, 16'sh0100, 0, 0);
    send_ray(16'sh0100, 0, 0, 16'sh0100, 0, 0);
    send_ray(0, 16'sh0100, 0, 16'sh0100, 0, 0);

    set_radius(16'hffff);
    send_ray(0, 0, 0, 16'sh0001, 0, 0);
    send_ray(16'sh8000, 16'sh8000, 16'sh8000, 16'sh0100, 16'sh0100, 16'sh0100);
    send_ray(16'sh7fff, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    random_rays(150);

    set_radius(16'd256);
    random_rays(200);
    set_radius(16'h0a00);
    random_rays(200);
    set_radius(16'($urandom_range(1, 65534)));
    random_rays(200);

    drain();
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
